>>> hdl/freu_pkg.sv
// Package for the four register opcode executor: data widths, opcode and
// ALU class codes, the decoded instruction format and the opcode decoder.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package freu_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int OPERAND_WIDTH = 16;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [3:0] {
      CMD_MULI = 4'd0,
      CMD_SETI = 4'd1,
      CMD_BANI = 4'd2,
      CMD_GTRI = 4'd3,
      CMD_GTRR = 4'd4,
      CMD_EQRR = 4'd5,
      CMD_ADDI = 4'd6,
      CMD_GTIR = 4'd7,
      CMD_EQIR = 4'd8,
      CMD_MULR = 4'd9,
      CMD_ADDR = 4'd10,
      CMD_BORR = 4'd11,
      CMD_BORI = 4'd12,
      CMD_EQRI = 4'd13,
      CMD_BANR = 4'd14,
      CMD_SETR = 4'd15
   } cmd_type;

   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_MUL = 3'd1,
      ALU_AND = 3'd2,
      ALU_OR  = 3'd3,
      ALU_SET = 3'd4,
      ALU_GT  = 3'd5,
      ALU_EQ  = 3'd6
   } alu_type;

   typedef struct packed {
      alu_type                  alu;
      logic                     a_is_reg;
      logic                     b_is_reg;
      logic                     bad;
      logic [OPERAND_WIDTH-1:0] op_a;
      logic [OPERAND_WIDTH-1:0] op_b;
      logic [OPERAND_WIDTH-1:0] dest;
   } entry_type;

   function automatic alu_type decode_alu(input cmd_type cmd);
      alu_type alu;
      unique case (cmd) inside
         CMD_ADDR, CMD_ADDI: alu = ALU_ADD;
         CMD_MULR, CMD_MULI: alu = ALU_MUL;
         CMD_BANR, CMD_BANI: alu = ALU_AND;
         CMD_BORR, CMD_BORI: alu = ALU_OR;
         CMD_SETR, CMD_SETI: alu = ALU_SET;
         CMD_GTIR, CMD_GTRI, CMD_GTRR: alu = ALU_GT;
         CMD_EQIR, CMD_EQRI, CMD_EQRR: alu = ALU_EQ;
         default: alu = ALU_EQ;
      endcase
      return alu;
   endfunction

   function automatic logic a_uses_reg(input cmd_type cmd);
      logic used;
      unique case (cmd) inside
         CMD_SETI, CMD_GTIR, CMD_EQIR: used = 1'b0;
         default: used = 1'b1;
      endcase
      return used;
   endfunction

   function automatic logic b_uses_reg(input cmd_type cmd);
      logic used;
      unique case (cmd) inside
         CMD_GTRR, CMD_EQRR, CMD_GTIR, CMD_EQIR, CMD_MULR, CMD_ADDR, CMD_BORR, CMD_BANR:
            used = 1'b1;
         default: used = 1'b0;
      endcase
      return used;
   endfunction

endpackage

`default_nettype wire

>>> hdl/four_register_opcode_executor_unit.sv
// Top level of the four register opcode executor: front end, queue and
// back end. Depends on freu_pkg, freu_front, freu_queue and freu_back.
// The unit executes one instruction transaction per clock cycle in steady
// state while rsp_stall is low. A transaction is decoded and written into the
// queue when it is accepted, and is executed against the register file once
// it is at the head of the queue and the output register is free; its result
// is then held in the output register until taken. The execute cycle, with its
// 32-bit multiplier and register file write, sets the rate; each instruction
// sees the registers left by the one before it. The register file is cleared
// by reset. An index of NUM_REGS or above raises bad_index and writes nothing.
`default_nettype none

module four_register_opcode_executor_unit #(
   parameter int NUM_REGS = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [3:0]                             req_command,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0]     req_operand_a,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0]     req_operand_b,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0]     req_dest_index,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_written_value,
   output logic                                        rsp_bad_index,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r0,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r1,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r2,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r3
);
   import freu_pkg::*;

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   entry_type q_push_entry;
   entry_type q_head;

   freu_front #(
      .NUM_REGS(NUM_REGS)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_dest_index(req_dest_index),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_push_entry  (q_push_entry)
   );

   freu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   freu_back #(
      .NUM_REGS(NUM_REGS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_written_value(rsp_written_value),
      .rsp_bad_index    (rsp_bad_index),
      .rsp_value_r0     (rsp_value_r0),
      .rsp_value_r1     (rsp_value_r1),
      .rsp_value_r2     (rsp_value_r2),
      .rsp_value_r3     (rsp_value_r3)
   );

endmodule

`default_nettype wire

>>> hdl/freu_front.sv
// Front end: accepts instruction transactions, decodes the opcode and checks
// register indices, then pushes the decoded entry into the queue.
// Depends on freu_pkg.
`default_nettype none

module freu_front #(
   parameter int NUM_REGS = 4
) (
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [3:0]                         req_command,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   input  wire logic [freu_pkg::OPERAND_WIDTH-1:0] req_dest_index,
   input  wire logic                               q_full,
   output logic                                    q_push,
   output freu_pkg::entry_type                     q_push_entry
);
   import freu_pkg::*;

   localparam logic [OPERAND_WIDTH-1:0] REG_LIMIT = OPERAND_WIDTH'(NUM_REGS);

   cmd_type cmd;
   logic    a_reg;
   logic    b_reg;

   assign cmd       = cmd_type'(req_command);
   assign a_reg     = a_uses_reg(cmd);
   assign b_reg     = b_uses_reg(cmd);
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_push_entry.alu      = decode_alu(cmd);
      q_push_entry.a_is_reg = a_reg;
      q_push_entry.b_is_reg = b_reg;
      q_push_entry.bad      = (req_dest_index >= REG_LIMIT)
                              || (a_reg && (req_operand_a >= REG_LIMIT))
                              || (b_reg && (req_operand_b >= REG_LIMIT));
      q_push_entry.op_a     = req_operand_a;
      q_push_entry.op_b     = req_operand_b;
      q_push_entry.dest     = req_dest_index;
   end

endmodule

`default_nettype wire

>>> hdl/freu_queue.sv
// Short queue of decoded instructions between the front end and the back end.
// Depends on freu_pkg.
`default_nettype none

module freu_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire freu_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     empty,
   output freu_pkg::entry_type      head
);
   import freu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Queue written while full.");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("Queue read while empty.");
`endif

endmodule

`default_nettype wire

>>> hdl/freu_back.sv
// Back end: executes the queued instruction against the register file and
// holds the result transaction in the output register.
// Depends on freu_pkg.
`default_nettype none

module freu_back #(
   parameter int NUM_REGS = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   q_empty,
   input  wire freu_pkg::entry_type                    q_head,
   output logic                                        q_pop,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_written_value,
   output logic                                        rsp_bad_index,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r0,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r1,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r2,
   output logic signed [freu_pkg::DATA_WIDTH-1:0]      rsp_value_r3
);
   import freu_pkg::*;

   localparam int IDX_W = $clog2(NUM_REGS);
   localparam logic [OPERAND_WIDTH-1:0] REG_LIMIT = OPERAND_WIDTH'(NUM_REGS);
   localparam int NUM_PORTS = 4;

   logic [NUM_REGS-1:0][DATA_WIDTH-1:0]  rf_ff, rf_in;
   logic [NUM_PORTS-1:0][DATA_WIDTH-1:0] snap;
   logic [NUM_PORTS-1:0][DATA_WIDTH-1:0] snap_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]                written_ff, written_in;
   logic                                 bad_ff;
   logic                                 advance;
   logic [DATA_WIDTH-1:0]                ra, rb, va, vb, res;
   logic signed [DATA_WIDTH:0]           xa, xb;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign q_pop        = !q_empty && advance;
   assign rsp_valid_in = advance ? !q_empty : rsp_valid_ff;

   always_comb begin
      ra = '0;
      rb = '0;
      if (q_head.op_a < REG_LIMIT) begin
         ra = rf_ff[q_head.op_a[IDX_W-1:0]];
      end
      if (q_head.op_b < REG_LIMIT) begin
         rb = rf_ff[q_head.op_b[IDX_W-1:0]];
      end
      va = q_head.a_is_reg ? ra : DATA_WIDTH'(q_head.op_a);
      vb = q_head.b_is_reg ? rb : DATA_WIDTH'(q_head.op_b);
      xa = q_head.a_is_reg ? {ra[DATA_WIDTH-1], ra} : {1'b0, va};
      xb = q_head.b_is_reg ? {rb[DATA_WIDTH-1], rb} : {1'b0, vb};
      case (q_head.alu)
         ALU_ADD: res = va + vb;
         ALU_MUL: res = va * vb;
         ALU_AND: res = va & vb;
         ALU_OR:  res = va | vb;
         ALU_SET: res = va;
         ALU_GT:  res = DATA_WIDTH'(xa > xb);
         ALU_EQ:  res = DATA_WIDTH'(xa == xb);
         default: res = '0;
      endcase
      written_in = q_head.bad ? '0 : res;
   end

   always_comb begin
      rf_in = rf_ff;
      if (q_pop && !q_head.bad) begin
         rf_in[q_head.dest[IDX_W-1:0]] = res;
      end
   end

   for (genvar k = 0; k < NUM_PORTS; k++) begin : g_snap
      if (k < NUM_REGS) begin : g_present
         assign snap[k] = rf_in[k];
      end else begin : g_absent
         assign snap[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rf_ff        <= rf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         written_ff <= written_in;
         bad_ff     <= q_head.bad;
         snap_ff    <= snap;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_written_value = written_ff;
   assign rsp_bad_index     = bad_ff;
   assign rsp_value_r0      = snap_ff[0];
   assign rsp_value_r1      = snap_ff[1];
   assign rsp_value_r2      = snap_ff[2];
   assign rsp_value_r3      = snap_ff[3];

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.bad) |=> $stable(rf_ff))
      else $error("Register file changed by an instruction with a bad index.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_index) |-> (rsp_written_value == '0))
      else $error("Bad index transaction reports a nonzero value.");
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_head.bad && (q_head.alu == ALU_GT || q_head.alu == ALU_EQ))
      |=> (rsp_written_value[DATA_WIDTH-1:1] == '0))
      else $error("Compare produced a value other than zero or one.");
   assert property (@(posedge clock) disable iff (reset)
      (!q_empty && rsp_valid && !rsp_stall) |-> q_pop)
      else $error("Queued instruction not issued while the output drains.");
`endif

endmodule

`default_nettype wire
